// File: src/u8d_pkg.sv
// Shared types, constants and helper functions for the UTF-8 stream decoder.
// Used by the front classifier, the byte queue and the decode back end.
// No dependencies.
package u8d_pkg;

  localparam int unsigned MAX_STRING_BYTES = 65536;
  localparam int unsigned POS_W = 17;
  localparam int unsigned CP_W = 21;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_STRING_BYTES);

  localparam logic [7:0] ASCII_END = 8'h80;
  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD3_MIN = 8'he0;
  localparam logic [7:0] LEAD4_MIN = 8'hf0;
  localparam logic [7:0] LEAD4_MAX = 8'hf4;
  localparam logic [7:0] TRAIL_END = 8'hc0;
  localparam logic [1:0] TRAIL_TAG = 2'b10;

  localparam logic [7:0] LEAD3_OK [16] = '{
    8'h20, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30,
    8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h10, 8'h30, 8'h30
  };
  localparam logic [7:0] LEAD4_OK [16] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h1e, 8'h0f, 8'h0f, 8'h0f, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_TRAIL,
    CLS_BAD
  } byte_class_t;

  typedef enum logic [1:0] {
    SEQ_NONE,
    SEQ_TWO,
    SEQ_THREE,
    SEQ_FOUR
  } seq_kind_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic        last_byte;
    byte_class_t cls;
  } q_entry_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    if (b < ASCII_END) c = CLS_ASCII;
    else if (b < TRAIL_END) c = CLS_TRAIL;
    else if (b < LEAD2_MIN) c = CLS_BAD;
    else if (b < LEAD3_MIN) c = CLS_LEAD2;
    else if (b < LEAD4_MIN) c = CLS_LEAD3;
    else if (b <= LEAD4_MAX) c = CLS_LEAD4;
    else c = CLS_BAD;
    return c;
  endfunction

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
    return (p >= POS_MAX) ? POS_MAX : p + POS_W'(1);
  endfunction

  // The first trail byte of a three- or four-byte sequence has a range that
  // depends on the lead byte; all other trail bytes only need the 10xxxxxx tag.
  function automatic logic first_trail_ok(input seq_kind_t seq, input logic [3:0] lead_bits,
                                          input logic [7:0] b);
    logic ok;
    case (seq)
      SEQ_THREE: ok = LEAD3_OK[lead_bits][b[7:5]];
      SEQ_FOUR:  ok = LEAD4_OK[b[7:4]][lead_bits[2:0]];
      default:   ok = (b[7:6] == TRAIL_TAG);
    endcase
    return ok;
  endfunction

endpackage

// File: src/u8d_front.sv
// Front end of the UTF-8 stream decoder: accepts bytes and tags each with its class.
// Depends on u8d_pkg; feeds u8d_queue.
module u8d_front (
  input  logic             byte_valid,
  output logic             byte_stall,
  input  logic [7:0]       byte_value,
  input  logic             last_byte,
  input  logic             queue_full,
  output logic             push,
  output u8d_pkg::q_entry_t push_entry
);
  import u8d_pkg::*;

  assign byte_stall = queue_full;
  assign push = byte_valid && !queue_full;

  always_comb begin
    push_entry.byte_value = byte_value;
    push_entry.last_byte = last_byte;
    push_entry.cls = classify(byte_value);
  end

endmodule

// File: src/u8d_queue.sv
// Short queue of classified bytes between the decoder front and back ends.
// Depends on u8d_pkg.
module u8d_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  u8d_pkg::q_entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output u8d_pkg::q_entry_t head
);
  import u8d_pkg::*;

  q_entry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

endmodule

// File: src/u8d_back.sv
// Back end of the UTF-8 stream decoder: sequence state, checks and the result register.
// Depends on u8d_pkg; takes classified bytes from u8d_queue.
module u8d_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  u8d_pkg::q_entry_t           head,
  output logic                        pop,
  input  logic                        cfg_valid,
  input  logic                        cfg_data,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [u8d_pkg::CP_W-1:0]    code_point,
  output logic                        point_valid,
  output logic                        end_of_string,
  output logic                        error_flag,
  output logic [u8d_pkg::POS_W-1:0]   error_offset
);
  import u8d_pkg::*;

  logic              emit_code_points;
  logic [15:0]       partial_value, partial_value_next;
  logic [1:0]        trail_remaining, trail_remaining_next;
  seq_kind_t         sequence_kind, sequence_kind_next;
  logic              first_trail_pending, first_trail_pending_next;
  logic              dropping_rest, dropping_rest_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;

  logic [7:0]        b;
  logic              last;
  logic              in_seq;
  logic              is_lead;
  logic              trail_ok;
  logic              do_fail;
  logic              do_done;
  logic [POS_W-1:0]  pos_inc;
  logic [POS_W-1:0]  fail_off;
  logic [CP_W-1:0]   done_cp;

  logic              res_en;
  logic [CP_W-1:0]   res_cp;
  logic              res_pv;
  logic              res_eos;
  logic              res_err;
  logic [POS_W-1:0]  res_off;

  assign pop = head_valid && (!result_valid || !result_stall);

  assign b = head.byte_value;
  assign last = head.last_byte;
  assign in_seq = (sequence_kind != SEQ_NONE);
  assign is_lead = (head.cls == CLS_LEAD2) || (head.cls == CLS_LEAD3) ||
                   (head.cls == CLS_LEAD4);
  assign trail_ok = first_trail_pending ? first_trail_ok(sequence_kind, partial_value[3:0], b)
                                        : (head.cls == CLS_TRAIL);
  assign pos_inc = sat_inc(byte_position);

  assign do_fail = !dropping_rest && (
      (!in_seq && (head.cls == CLS_BAD || head.cls == CLS_TRAIL)) ||
      (!in_seq && is_lead && last) ||
      (in_seq && !trail_ok) ||
      (in_seq && trail_ok && trail_remaining > 2'd1 && last));
  assign do_done = !dropping_rest && (
      (!in_seq && head.cls == CLS_ASCII) ||
      (in_seq && trail_ok && trail_remaining <= 2'd1));
  assign fail_off = (in_seq && !trail_ok) ? byte_position : pos_inc;
  assign done_cp = in_seq ? {partial_value[14:0], b[5:0]} : {{(CP_W-8){1'b0}}, b};

  always_comb begin
    partial_value_next = partial_value;
    trail_remaining_next = trail_remaining;
    sequence_kind_next = sequence_kind;
    first_trail_pending_next = first_trail_pending;
    dropping_rest_next = dropping_rest;
    byte_position_next = byte_position;
    if (pop) begin
      if (dropping_rest) begin
        if (last) begin
          dropping_rest_next = 1'b0;
          byte_position_next = '0;
        end
      end else if (do_fail || do_done) begin
        partial_value_next = '0;
        trail_remaining_next = '0;
        sequence_kind_next = SEQ_NONE;
        first_trail_pending_next = 1'b0;
        if (last) begin
          byte_position_next = '0;
        end else if (do_fail) begin
          dropping_rest_next = 1'b1;
        end else begin
          byte_position_next = pos_inc;
        end
      end else if (!in_seq) begin
        first_trail_pending_next = 1'b1;
        byte_position_next = pos_inc;
        unique case (head.cls)
          CLS_LEAD2: begin
            sequence_kind_next = SEQ_TWO;
            trail_remaining_next = 2'd1;
            partial_value_next = {11'b0, b[4:0]};
          end
          CLS_LEAD3: begin
            sequence_kind_next = SEQ_THREE;
            trail_remaining_next = 2'd2;
            partial_value_next = {12'b0, b[3:0]};
          end
          default: begin
            sequence_kind_next = SEQ_FOUR;
            trail_remaining_next = 2'd3;
            partial_value_next = {13'b0, b[2:0]};
          end
        endcase
      end else begin
        partial_value_next = {partial_value[9:0], b[5:0]};
        trail_remaining_next = trail_remaining - 2'd1;
        first_trail_pending_next = 1'b0;
        byte_position_next = pos_inc;
      end
    end
  end

  always_comb begin
    res_en = 1'b0;
    res_cp = '0;
    res_pv = 1'b0;
    res_eos = 1'b0;
    res_err = 1'b0;
    res_off = '0;
    if (pop && do_fail) begin
      res_en = 1'b1;
      res_eos = 1'b1;
      res_err = 1'b1;
      res_off = fail_off;
    end else if (pop && do_done) begin
      res_en = emit_code_points || last;
      res_pv = emit_code_points;
      res_cp = emit_code_points ? done_cp : '0;
      res_eos = last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_code_points <= 1'b1;
      partial_value <= '0;
      trail_remaining <= '0;
      sequence_kind <= SEQ_NONE;
      first_trail_pending <= 1'b0;
      dropping_rest <= 1'b0;
      byte_position <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) emit_code_points <= cfg_data;
      partial_value <= partial_value_next;
      trail_remaining <= trail_remaining_next;
      sequence_kind <= sequence_kind_next;
      first_trail_pending <= first_trail_pending_next;
      dropping_rest <= dropping_rest_next;
      byte_position <= byte_position_next;
      if (res_en) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_en) begin
      code_point <= res_cp;
      point_valid <= res_pv;
      end_of_string <= res_eos;
      error_flag <= res_err;
      error_offset <= res_off;
    end
  end

endmodule

// File: src/utf8_stream_decoder_core.sv
// Strict UTF-8 decoder and validator, one byte word per cycle unless results stall.
// An accepted byte is written into the byte queue; the back end decodes the queue head
// and loads its result into the result register, which holds while results stall.
// Throughput: one byte per cycle unless results stall; the back end decodes the head
// combinationally. The four-entry byte queue lets input flow on while results stall.
// Synchronous active-high reset empties the queue and result register, clears the
// sequence state and sets emit_code_points to 1.
module utf8_stream_decoder_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  output logic                        byte_stall,
  input  logic [7:0]                  byte_value,
  input  logic                        last_byte,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [u8d_pkg::CP_W-1:0]    code_point,
  output logic                        point_valid,
  output logic                        end_of_string,
  output logic                        error_flag,
  output logic [u8d_pkg::POS_W-1:0]   error_offset
);
  import u8d_pkg::*;

  logic     queue_full;
  logic     push;
  q_entry_t push_entry;
  logic     pop;
  logic     head_valid;
  q_entry_t head;

  assign cfg_ready = 1'b1;

  u8d_front u_front (
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  u8d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  u8d_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .code_point    (code_point),
    .point_valid   (point_valid),
    .end_of_string (end_of_string),
    .error_flag    (error_flag),
    .error_offset  (error_offset)
  );

endmodule

// File: src/u8d_checker.sv
// Port-level checks for the UTF-8 stream decoder, bound to its top level.
// Depends on u8d_pkg and utf8_stream_decoder_core.
module u8d_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        result_valid,
  input logic                        result_stall,
  input logic [u8d_pkg::CP_W-1:0]    code_point,
  input logic                        point_valid,
  input logic                        end_of_string,
  input logic                        error_flag,
  input logic [u8d_pkg::POS_W-1:0]   error_offset
);
  import u8d_pkg::*;

  // An error always closes the string and never carries a code point.
  a_error_closes: assert property (@(posedge clk) disable iff (rst)
    result_valid && error_flag |-> end_of_string && !point_valid && code_point == '0)
    else $error("error result without end of string");

  a_ok_zero_offset: assert property (@(posedge clk) disable iff (rst)
    result_valid && !error_flag |-> error_offset == '0)
    else $error("nonzero offset on a good result");

  // A decoded value is a scalar value: in range and not a surrogate.
  a_scalar: assert property (@(posedge clk) disable iff (rst)
    result_valid && point_valid |->
      code_point <= CP_W'(21'h10ffff) &&
      !(code_point >= CP_W'(21'hd800) && code_point <= CP_W'(21'hdfff)))
    else $error("code point outside the scalar range");

  a_error_offset_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && error_flag |-> error_offset != '0)
    else $error("error reported at offset zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(code_point) &&
      $stable(error_offset) && $stable(end_of_string))
    else $error("stalled result changed");

endmodule

bind utf8_stream_decoder_core u8d_checker u_u8d_checker (.*);

// File: dv/tb_utf8_stream_decoder_core.sv
// Self-checking testbench for utf8_stream_decoder_core: a directed table and random
// strings, scored against a byte-level decoder model kept inside this file.
// Depends on u8d_pkg and the core, together with the source files of the core.
module tb_utf8_stream_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import u8d_pkg::*;

  localparam int unsigned STRING_CAP = 65536;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_BYTES = 360;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned REPORT_CAP = 200;

  localparam logic [7:0] LEAD3_RANGES [16] = '{
    8'h20, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30,
    8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h10, 8'h30, 8'h30
  };
  localparam logic [7:0] LEAD4_RANGES [16] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h1e, 8'h0f, 8'h0f, 8'h0f, 8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam logic [20:0] EDGE_POINTS [9] = '{
    21'h7f, 21'h80, 21'h7ff, 21'h800, 21'hd7ff, 21'he000, 21'hffff, 21'h10000, 21'h10ffff
  };

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_SILENT,
    ROW_POINT,
    ROW_ERROR
  } row_kind_t;

  typedef struct packed {
    logic [20:0] cp;
    logic        pv;
    logic        eos;
    logic        err;
    logic [16:0] off;
  } decode_result_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        lst;
    row_kind_t   kind;
    logic [20:0] cp;
    logic [16:0] off;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_stall;
  logic [7:0] byte_value = 8'h00;
  logic last_byte = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [CP_W-1:0] code_point;
  logic point_valid;
  logic end_of_string;
  logic error_flag;
  logic [POS_W-1:0] error_offset;

  // Decoder model state.
  logic emit_points = 1'b1;
  logic [15:0] part_bits = '0;
  logic [1:0] trails_left = '0;
  seq_kind_t seq_now = SEQ_NONE;
  logic first_trail = 1'b0;
  logic skipping = 1'b0;
  int unsigned pos_now = 0;

  decode_result_t awaited_results [$];
  plan_row_t plan [$];
  row_kind_t cur_kind = ROW_PREDICT;
  logic [20:0] cur_cp = '0;
  logic [16:0] cur_off = '0;
  int unsigned fails = 0;
  int unsigned results_seen = 0;
  bit calm = 1'b0;
  int unsigned hold_asked = 0;

  utf8_stream_decoder_core u_top (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_value(byte_value),
    .last_byte(last_byte),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .code_point(code_point),
    .point_valid(point_valid),
    .end_of_string(end_of_string),
    .error_flag(error_flag),
    .error_offset(error_offset)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned cap_pos(input int unsigned v);
    return (v > STRING_CAP) ? STRING_CAP : v;
  endfunction

  function automatic void restart_string();
    part_bits = '0;
    trails_left = '0;
    seq_now = SEQ_NONE;
    first_trail = 1'b0;
    skipping = 1'b0;
    pos_now = 0;
  endfunction

  function automatic void flag_error(input int unsigned off, input logic lst,
                                     output bit has, output decode_result_t r);
    has = 1'b1;
    r = '0;
    r.eos = 1'b1;
    r.err = 1'b1;
    r.off = 17'(cap_pos(off));
    if (lst) begin
      restart_string();
    end else begin
      part_bits = '0;
      trails_left = '0;
      seq_now = SEQ_NONE;
      first_trail = 1'b0;
      skipping = 1'b1;
    end
  endfunction

  function automatic void close_point(input logic [20:0] cp, input logic lst,
                                      output bit has, output decode_result_t r);
    part_bits = '0;
    trails_left = '0;
    seq_now = SEQ_NONE;
    first_trail = 1'b0;
    r = '0;
    if (lst) begin
      restart_string();
      has = 1'b1;
      r.eos = 1'b1;
      if (emit_points) begin
        r.cp = cp;
        r.pv = 1'b1;
      end
    end else begin
      pos_now = cap_pos(pos_now + 1);
      has = emit_points;
      r.cp = cp;
      r.pv = 1'b1;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic lst,
                                      output bit has, output decode_result_t r);
    int unsigned at;
    bit ok;
    has = 1'b0;
    r = '0;
    at = pos_now;
    if (skipping) begin
      if (lst) restart_string();
      return;
    end
    if (seq_now == SEQ_NONE) begin
      if (b < 8'h80) begin
        close_point(21'(b), lst, has, r);
        return;
      end
      if (b >= 8'he0 && b < 8'hf0) begin
        seq_now = SEQ_THREE;
        trails_left = 2'd2;
        part_bits = 16'(b[3:0]);
      end else if (b >= 8'hf0) begin
        if (b > 8'hf4) begin
          flag_error(at + 1, lst, has, r);
          return;
        end
        seq_now = SEQ_FOUR;
        trails_left = 2'd3;
        part_bits = 16'(b[2:0]);
      end else if (b >= 8'hc2) begin
        seq_now = SEQ_TWO;
        trails_left = 2'd1;
        part_bits = 16'(b[4:0]);
      end else begin
        flag_error(at + 1, lst, has, r);
        return;
      end
      first_trail = 1'b1;
      if (lst) begin
        flag_error(at + 1, 1'b1, has, r);
        return;
      end
      pos_now = cap_pos(at + 1);
      return;
    end
    if (first_trail && seq_now == SEQ_THREE) begin
      ok = LEAD3_RANGES[part_bits[3:0]][b[7:5]];
    end else if (first_trail && seq_now == SEQ_FOUR) begin
      ok = LEAD4_RANGES[b[7:4]][part_bits[2:0]];
    end else begin
      ok = (b[7:6] == 2'b10);
    end
    if (!ok) begin
      flag_error(at, lst, has, r);
      return;
    end
    first_trail = 1'b0;
    if (trails_left <= 2'd1) begin
      close_point(21'({part_bits, b[5:0]}), lst, has, r);
      return;
    end
    part_bits = {part_bits[9:0], b[5:0]};
    trails_left = trails_left - 2'd1;
    if (lst) begin
      flag_error(at + 1, 1'b1, has, r);
      return;
    end
    pos_now = cap_pos(at + 1);
  endfunction

  function automatic void check_field(input string name, input logic [20:0] want,
                                      input logic [20:0] got);
    if (want !== got) begin
      fails++;
      if (fails <= REPORT_CAP) $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic lst, input row_kind_t kind,
                                  input logic [20:0] cp, input logic [16:0] off);
    plan_row_t row;
    row.b = b;
    row.lst = lst;
    row.kind = kind;
    row.cp = cp;
    row.off = off;
    plan.push_back(row);
  endfunction

  always @(posedge clk) begin : watch_ports
    decode_result_t want;
    bit has;
    bit moved;
    int unsigned quiet;
    if (!rst) begin
      moved = 1'b0;
      if (byte_valid && !byte_stall) begin
        moved = 1'b1;
        decode_byte(byte_value, last_byte, has, want);
        case (cur_kind)
          ROW_SILENT: begin
            has = 1'b0;
          end
          ROW_POINT: begin
            has = 1'b1;
            want = '0;
            want.cp = cur_cp;
            want.pv = 1'b1;
            want.eos = last_byte;
          end
          ROW_ERROR: begin
            has = 1'b1;
            want = '0;
            want.eos = 1'b1;
            want.err = 1'b1;
            want.off = cur_off;
          end
          default: begin
          end
        endcase
        if (has) awaited_results.push_back(want);
      end
      if (result_valid && !result_stall) begin
        moved = 1'b1;
        results_seen++;
        if (awaited_results.size() == 0) begin
          fails++;
          if (fails <= REPORT_CAP) begin
            $error("unexpected result: code_point %0h point_valid %0b end_of_string %0b",
                   code_point, point_valid, end_of_string);
          end
        end else begin
          want = awaited_results.pop_front();
          check_field("code_point", want.cp, code_point);
          check_field("point_valid", 21'(want.pv), 21'(point_valid));
          check_field("end_of_string", 21'(want.eos), 21'(end_of_string));
          check_field("error_flag", 21'(want.err), 21'(error_flag));
          check_field("error_offset", 21'(want.off), 21'(error_offset));
        end
      end
      if (cfg_valid && cfg_ready) moved = 1'b1;
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end else begin
      quiet = 0;
    end
  end

  initial begin : result_sink
    int unsigned hold_left;
    int unsigned hold_done;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_done != hold_asked) begin
        hold_done = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= !calm && ($urandom_range(99) < 24);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic push_byte(input logic [7:0] b, input logic lst, input row_kind_t kind,
                           input logic [20:0] cp, input logic [16:0] off);
    while (!calm && $urandom_range(99) < 24) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_value <= b;
    last_byte <= lst;
    cur_kind <= kind;
    cur_cp <= cp;
    cur_off <= off;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // The mode is changed only once every result in flight has been drained.
  task automatic set_mode(input logic v);
    byte_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    emit_points = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] text [$];
    logic [20:0] cp;
    int unsigned sent;
    int unsigned base;
    int unsigned pick;
    int unsigned at;
    add_row(8'h00, 1'b0, ROW_POINT, 21'h0, '0);
    add_row(8'h7f, 1'b1, ROW_POINT, 21'h7f, '0);
    add_row(8'hc2, 1'b0, ROW_PREDICT, '0, '0);
    add_row(8'h80, 1'b1, ROW_PREDICT, '0, '0);
    add_row(8'hf4, 1'b0, ROW_PREDICT, '0, '0);
    add_row(8'h8f, 1'b0, ROW_PREDICT, '0, '0);
    add_row(8'hbf, 1'b0, ROW_PREDICT, '0, '0);
    add_row(8'hbf, 1'b1, ROW_POINT, 21'h10ffff, '0);
    add_row(8'hc1, 1'b1, ROW_ERROR, '0, 17'd1);
    add_row(8'h41, 1'b0, ROW_POINT, 21'h41, '0);
    add_row(8'hf5, 1'b0, ROW_ERROR, '0, 17'd2);
    add_row(8'h20, 1'b1, ROW_SILENT, '0, '0);
    add_row(8'he0, 1'b0, ROW_PREDICT, '0, '0);
    add_row(8'h9f, 1'b1, ROW_ERROR, '0, 17'd1);
    add_row(8'hed, 1'b0, ROW_PREDICT, '0, '0);
    add_row(8'ha0, 1'b0, ROW_ERROR, '0, 17'd1);
    add_row(8'h80, 1'b1, ROW_SILENT, '0, '0);
    add_row(8'hf4, 1'b0, ROW_PREDICT, '0, '0);
    add_row(8'h90, 1'b1, ROW_ERROR, '0, 17'd1);
    add_row(8'hf0, 1'b0, ROW_PREDICT, '0, '0);
    add_row(8'h8f, 1'b1, ROW_ERROR, '0, 17'd1);
    add_row(8'he1, 1'b0, ROW_PREDICT, '0, '0);
    add_row(8'h80, 1'b1, ROW_ERROR, '0, 17'd2);
    add_row(8'hdf, 1'b0, ROW_PREDICT, '0, '0);
    add_row(8'h41, 1'b1, ROW_ERROR, '0, 17'd1);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) push_byte(plan[i].b, plan[i].lst, plan[i].kind, plan[i].cp, plan[i].off);

    // Phases alternate the mode; a phase may end in the middle of a string.
    for (int ph = 0; ph < 4; ph++) begin
      set_mode(ph % 2 == 0);
      calm = (ph == 2);
      if (ph == 2) hold_asked++;
      sent = 0;
      base = results_seen;
      while (sent < PHASE_BYTES ||
             (!emit_points && results_seen - base < 30 && sent < 2 * PHASE_BYTES)) begin
        if (text.size() == 0) begin
          pick = $urandom_range(99);
          if (pick >= 94) begin
            repeat ($urandom_range(10, 1)) text.push_back(8'($urandom_range(255)));
          end else begin
            repeat ($urandom_range(8, 1)) begin
              case ($urandom_range(4))
                0: cp = 21'($urandom_range(21'h7f));
                1: cp = 21'($urandom_range(21'h7ff, 21'h80));
                2: begin
                  cp = 21'($urandom_range(21'hffff, 21'h800));
                  if (cp >= 21'hd800 && cp <= 21'hdfff) cp = cp - 21'h800;
                end
                3: cp = 21'($urandom_range(21'h10ffff, 21'h10000));
                default: cp = EDGE_POINTS[$urandom_range(8)];
              endcase
              if (cp < 21'h80) begin
                text.push_back(cp[7:0]);
              end else if (cp < 21'h800) begin
                text.push_back({3'b110, cp[10:6]});
                text.push_back({2'b10, cp[5:0]});
              end else if (cp < 21'h10000) begin
                text.push_back({4'b1110, cp[15:12]});
                text.push_back({2'b10, cp[11:6]});
                text.push_back({2'b10, cp[5:0]});
              end else begin
                text.push_back({5'b11110, cp[20:18]});
                text.push_back({2'b10, cp[17:12]});
                text.push_back({2'b10, cp[11:6]});
                text.push_back({2'b10, cp[5:0]});
              end
            end
            if (pick >= 70 && pick < 80) begin
              at = $urandom_range(text.size() - 1);
              text[at] = $urandom_range(1) ? 8'($urandom_range(8'hbf, 8'h80))
                                           : 8'($urandom_range(255));
            end else if (pick >= 80 && pick < 87) begin
              repeat ($urandom_range(3, 1)) if (text.size() > 1) void'(text.pop_back());
            end else if (pick >= 87) begin
              text.insert($urandom_range(text.size()), 8'($urandom_range(255)));
            end
          end
        end
        push_byte(text[0], text.size() == 1, ROW_PREDICT, '0, '0);
        void'(text.pop_front());
        sent++;
      end
    end

    // Finish the open string, then send a lone lead byte that is cut off by the end.
    calm = 1'b1;
    while (text.size() != 0) begin
      push_byte(text[0], text.size() == 1, ROW_PREDICT, '0, '0);
      void'(text.pop_front());
    end
    push_byte(8'he2, 1'b1, ROW_PREDICT, '0, '0);

    byte_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
src/u8d_pkg.sv
src/u8d_front.sv
src/u8d_queue.sv
src/u8d_back.sv
src/utf8_stream_decoder_core.sv
src/u8d_checker.sv
dv/tb_utf8_stream_decoder_core.sv
